FILE: sv/dmxd_pkg.sv
// Package for the lighting-universe delta chunk sender.
// Holds field widths, codes, the controller state type and memory strobes.
// No dependencies.
package dmxd_pkg;

    localparam int KIND_W = 2;
    localparam int ADDR_W = 10;
    localparam int BYTE_W = 8;
    localparam int TIME_W = 32;
    localparam int SEQ_W  = 16;
    localparam int OFF_W  = 9;
    localparam int LEN_W  = 10;
    localparam int UNI_W  = 8;
    localparam int IVL_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_UNIVERSE = 2'd0;
    localparam logic [1:0] REG_FAST     = 2'd1;
    localparam logic [1:0] REG_SLOW     = 2'd2;

    localparam logic [IVL_W-1:0] FAST_RESET = 16'd33;
    localparam logic [IVL_W-1:0] SLOW_RESET = 16'd100;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_COPY
    } t_state;

    typedef struct packed {
        logic cur_we;
        logic sent_we;
    } t_mem_ctl;

endpackage

FILE: sv/dmxd_store.sv
// Level stores of the delta chunk sender: current and last-sent copies.
// Two synchronous memories, one write and one read port each, with registered read data.
// Depends on dmxd_pkg.
module dmxd_store
    import dmxd_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_cur_waddr,
    input  logic [BYTE_W-1:0] i_cur_wdata,
    input  logic [AW-1:0]     i_cur_raddr,
    input  logic [AW-1:0]     i_sent_waddr,
    input  logic [BYTE_W-1:0] i_sent_wdata,
    input  logic [AW-1:0]     i_sent_raddr,
    output logic [BYTE_W-1:0] o_cur_rdata,
    output logic [BYTE_W-1:0] o_sent_rdata
);

    logic [BYTE_W-1:0] r_cur_mem  [DEPTH];
    logic [BYTE_W-1:0] r_sent_mem [DEPTH];
    logic [BYTE_W-1:0] r_cur_rdata;
    logic [BYTE_W-1:0] r_sent_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cur_we) begin
            r_cur_mem[i_cur_waddr] <= i_cur_wdata;
        end
        r_cur_rdata <= r_cur_mem[i_cur_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sent_we) begin
            r_sent_mem[i_sent_waddr] <= i_sent_wdata;
        end
        r_sent_rdata <= r_sent_mem[i_sent_raddr];
    end

    assign o_cur_rdata  = r_cur_rdata;
    assign o_sent_rdata = r_sent_rdata;

endmodule

FILE: sv/dmx_delta_chunk_sender.sv
// Delta chunk sender: a valid write word goes into the current store; a read word registers its result.
// A tick word scans both stores and decides; if it sends, it emits its chunks one after another,
// then copies the span into the last-sent store; the span is the changed range, else all entries.
// After reset a clearing pass zeroes every entry of both stores with busy held high.
// Results appear for one cycle with o_result_valid; the receiver cannot stall.
// Depends on dmxd_pkg and dmxd_store.
module dmx_delta_chunk_sender
    import dmxd_pkg::*;
#(
    parameter int UNIVERSE_SIZE = 512,
    parameter int CHUNK_MAX     = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [BYTE_W-1:0]  i_value,
    input  logic [TIME_W-1:0]  i_now_ms,
    // Result channel
    output logic               o_result_valid,
    output logic               o_is_chunk,
    output logic [UNI_W-1:0]   o_universe_out,
    output logic [SEQ_W-1:0]   o_sequence_res,
    output logic [OFF_W-1:0]   o_chunk_offset,
    output logic [LEN_W-1:0]   o_chunk_length,
    output logic [BYTE_W-1:0]  o_data_byte,
    output logic               o_last,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Store index width and a counter width that can also hold UNIVERSE_SIZE itself.
    localparam int AW = $clog2(UNIVERSE_SIZE);
    localparam int IW = $clog2(UNIVERSE_SIZE + 1);
    localparam logic [IW-1:0]     IDX_LAST  = IW'(UNIVERSE_SIZE - 1);
    localparam logic [IW-1:0]     IDX_END   = IW'(UNIVERSE_SIZE);
    localparam logic [AW-1:0]     TOP_ENTRY = AW'(UNIVERSE_SIZE - 1);
    localparam logic [ADDR_W-1:0] ADDR_MAX  = ADDR_W'(UNIVERSE_SIZE);
    localparam logic [LEN_W-1:0]  CHUNK_LEN = LEN_W'(CHUNK_MAX);

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase.
    // ------------------------------------------------------------------
    logic [UNI_W-1:0] r_universe;
    logic [IVL_W-1:0] r_fast_ivl;
    logic [IVL_W-1:0] r_slow_ivl;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_universe <= '0;
            r_fast_ivl <= FAST_RESET;
            r_slow_ivl <= SLOW_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_UNIVERSE: r_universe <= pwdata[UNI_W-1:0];
                REG_FAST:     r_fast_ivl <= pwdata[IVL_W-1:0];
                REG_SLOW:     r_slow_ivl <= pwdata[IVL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_UNIVERSE: prdata = PDATA_W'(r_universe);
            REG_FAST:     prdata = PDATA_W'(r_fast_ivl);
            REG_SLOW:     prdata = PDATA_W'(r_slow_ivl);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller registers.
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;
    logic              r_cp_vld;
    logic [AW-1:0]     r_cp_idx;
    logic              r_changed, n_changed;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [IW-1:0]     r_end, n_end;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_done, n_done;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_last_send, n_last_send;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic              r_rd_ok, n_rd_ok;

    // Result register: loaded in the read-result and emit states.
    logic              r_res_vld, n_res_vld;
    logic              r_is_chunk, n_is_chunk;
    logic [UNI_W-1:0]  r_uni_out, n_uni_out;
    logic [SEQ_W-1:0]  r_seq_out, n_seq_out;
    logic [OFF_W-1:0]  r_off_out, n_off_out;
    logic [LEN_W-1:0]  r_len_out, n_len_out;
    logic [BYTE_W-1:0] r_data_out, n_data_out;
    logic              r_last_out, n_last_out;

    // Memory interface.
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     cur_waddr, cur_raddr, sent_waddr;
    logic [BYTE_W-1:0] cur_wdata, sent_wdata;
    logic [BYTE_W-1:0] cur_rdata, sent_rdata;

    logic              accept;
    logic              addr_ok;
    logic [AW-1:0]     addr_entry;
    logic              diff_hit;
    logic [TIME_W-1:0] elapsed;
    logic              send_now;
    logic [LEN_W-1:0]  remain;
    logic [LEN_W-1:0]  chunk_len;
    logic [LEN_W-1:0]  chunk_off;
    logic              chunk_fin;
    logic [AW-1:0]     span_lo, span_hi;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign addr_ok    = (i_address != '0) && (i_address <= ADDR_MAX);
    assign addr_entry = AW'(i_address - ADDR_W'(1));

    // A scan compare lands in the cycle after its read was issued.
    assign diff_hit = r_cmp_vld && (cur_rdata != sent_rdata);

    // Wrapping elapsed time and the interval test of the decision cycle.
    assign elapsed  = r_now - r_last_send;
    assign send_now = r_changed ? (elapsed >= TIME_W'(r_fast_ivl))
                                : (elapsed >= TIME_W'(r_slow_ivl));
    assign span_lo  = r_changed ? r_lo : '0;
    assign span_hi  = r_changed ? r_hi : TOP_ENTRY;

    // Chunk slicing: the remaining span capped at the chunk size.
    assign remain    = r_total - r_done;
    assign chunk_len = (remain > CHUNK_LEN) ? CHUNK_LEN : remain;
    assign chunk_off = LEN_W'(r_lo) + r_done;
    assign chunk_fin = ((r_done + chunk_len) >= r_total);

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == IDX_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_TICK: n_state = S_SCAN;
                        KIND_READ: n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_IDLE;
            S_SCAN: begin
                if (r_idx == IDX_END) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = send_now ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (chunk_fin) n_state = S_COPY;
            end
            S_COPY: begin
                if (r_idx == r_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the controller: memory strobes, counters and result data.
    // ------------------------------------------------------------------
    always_comb begin
        mem_ctl     = '0;
        cur_waddr   = addr_entry;
        cur_wdata   = i_value;
        cur_raddr   = r_idx[AW-1:0];
        sent_waddr  = r_cp_idx;
        sent_wdata  = cur_rdata;

        n_idx       = r_idx;
        n_changed   = r_changed;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_end       = r_end;
        n_total     = r_total;
        n_done      = r_done;
        n_now       = r_now;
        n_last_send = r_last_send;
        n_seq       = r_seq;
        n_rd_ok     = r_rd_ok;

        n_res_vld   = 1'b0;
        n_is_chunk  = r_is_chunk;
        n_uni_out   = r_uni_out;
        n_seq_out   = r_seq_out;
        n_off_out   = r_off_out;
        n_len_out   = r_len_out;
        n_data_out  = r_data_out;
        n_last_out  = r_last_out;

        case (r_state)
            S_CLEAR: begin
                // Zero one entry of each store per cycle.
                mem_ctl.cur_we  = 1'b1;
                mem_ctl.sent_we = 1'b1;
                cur_waddr       = r_idx[AW-1:0];
                cur_wdata       = '0;
                sent_waddr      = r_idx[AW-1:0];
                sent_wdata      = '0;
                n_idx           = (r_idx == IDX_LAST) ? '0 : r_idx + IW'(1);
            end
            S_IDLE: begin
                cur_raddr = addr_entry;
                if (accept) begin
                    mem_ctl.cur_we = (i_kind == KIND_WRITE) && addr_ok;
                    n_rd_ok        = addr_ok;
                    n_now          = i_now_ms;
                    n_changed      = 1'b0;
                    n_idx          = '0;
                end
            end
            S_READ: begin
                n_res_vld  = 1'b1;
                n_is_chunk = 1'b0;
                n_uni_out  = '0;
                n_seq_out  = '0;
                n_off_out  = '0;
                n_len_out  = '0;
                n_data_out = r_rd_ok ? cur_rdata : '0;
                n_last_out = 1'b0;
            end
            S_SCAN: begin
                if (r_idx != IDX_END) n_idx = r_idx + IW'(1);
                // Entries arrive in ascending order: the first hit is the low end.
                if (diff_hit) begin
                    if (!r_changed) n_lo = r_cmp_idx;
                    n_hi      = r_cmp_idx;
                    n_changed = 1'b1;
                end
            end
            S_DECIDE: begin
                if (send_now) begin
                    n_last_send = r_now;
                    n_lo        = span_lo;
                    n_total     = LEN_W'(span_hi) - LEN_W'(span_lo) + LEN_W'(1);
                    n_end       = IW'(span_hi) + IW'(1);
                    n_done      = '0;
                end
            end
            S_EMIT: begin
                n_res_vld  = 1'b1;
                n_is_chunk = 1'b1;
                n_uni_out  = r_universe;
                n_seq_out  = r_seq;
                n_off_out  = chunk_off[OFF_W-1:0];
                n_len_out  = chunk_len;
                n_data_out = '0;
                n_last_out = chunk_fin;
                n_seq      = r_seq + SEQ_W'(1);
                n_done     = r_done + chunk_len;
                n_idx      = IW'(r_lo);
            end
            S_COPY: begin
                // Read current at the issue index, write it to last-sent in the following cycle.
                mem_ctl.sent_we = r_cp_vld;
                if (r_idx != r_end) n_idx = r_idx + IW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cp_vld    <= 1'b0;
            r_changed   <= 1'b0;
            r_seq       <= '0;
            r_last_send <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cmp_vld   <= (r_state == S_SCAN) && (r_idx != IDX_END);
            r_cp_vld    <= (r_state == S_COPY) && (r_idx != r_end);
            r_changed   <= n_changed;
            r_seq       <= n_seq;
            r_last_send <= n_last_send;
            r_res_vld   <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= r_idx[AW-1:0];
        r_cp_idx   <= r_idx[AW-1:0];
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_end      <= n_end;
        r_total    <= n_total;
        r_done     <= n_done;
        r_now      <= n_now;
        r_rd_ok    <= n_rd_ok;
        r_is_chunk <= n_is_chunk;
        r_uni_out  <= n_uni_out;
        r_seq_out  <= n_seq_out;
        r_off_out  <= n_off_out;
        r_len_out  <= n_len_out;
        r_data_out <= n_data_out;
        r_last_out <= n_last_out;
    end

    dmxd_store #(
        .DEPTH (UNIVERSE_SIZE),
        .AW    (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_cur_waddr  (cur_waddr),
        .i_cur_wdata  (cur_wdata),
        .i_cur_raddr  (cur_raddr),
        .i_sent_waddr (sent_waddr),
        .i_sent_wdata (sent_wdata),
        .i_sent_raddr (r_idx[AW-1:0]),
        .o_cur_rdata  (cur_rdata),
        .o_sent_rdata (sent_rdata)
    );

    assign o_result_valid = r_res_vld;
    assign o_is_chunk     = r_is_chunk;
    assign o_universe_out = r_uni_out;
    assign o_sequence_res = r_seq_out;
    assign o_chunk_offset = r_off_out;
    assign o_chunk_length = r_len_out;
    assign o_data_byte    = r_data_out;
    assign o_last         = r_last_out;

`ifndef SYNTHESIS
    // A result only follows a read-result or emit cycle.
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_READ || $past(r_state) == S_EMIT))
        else $error("result strobe without a producing state");

    // The final chunk of a run is always followed by the copy pass.
    a_last_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |-> (r_state == S_COPY))
        else $error("final chunk not followed by copy");

    // Pending copy writes exist only inside the copy pass.
    a_copy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == S_COPY))
        else $error("last-sent write outside copy pass");

    // Scan compares only land in the scan state.
    a_scan_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SCAN))
        else $error("scan compare outside scan");
`endif

endmodule
